// File: rtl/core/art_pkg.sv
// Package for the ack/retransmit slot table: command and status codes,
// slot entry and result types, shared widths. No dependencies.
`default_nettype none
package art_pkg;

  localparam int DEF_SLOTS   = 32;  // default number of slots
  localparam int MAX_RES     = 32;  // results per tick
  localparam int ID_W        = 16;
  localparam int QOS_W       = 2;
  localparam int CNT2_W      = 2;   // ack / resend counters, config regs
  localparam int STATUS_W    = 4;
  localparam int SLOT_FLD_W  = 5;
  localparam int EMIT_W      = $clog2(MAX_RES + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CNT2_W-1:0] ATR_RESET = 2'd2;
  localparam logic [CNT2_W-1:0] LIM_RESET = 2'd3;
  localparam logic [CNT2_W-1:0] CNT_MAX   = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ACK    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACKS_TO_RELEASE = 1'b0,
    REG_RESEND_LIMIT    = 1'b1
  } reg_idx_t;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 4'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_COUNTED  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 4'd4;
  localparam logic [STATUS_W-1:0] ST_BADID    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_RESEND   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 4'd8;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [QOS_W-1:0]  qos;
    logic [CNT2_W-1:0] acks;
    logic [CNT2_W-1:0] resends;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_FLD_W-1:0] slot;
    logic [ID_W-1:0]       rid;
    logic [QOS_W-1:0]      rqos;
    logic                  last;
  } res_t;

  // per-step control from the head processor to the sequencer
  typedef struct packed {
    logic hit;      // command satisfied at this slot
    logic emit;     // a result leaves at this step
    logic cnt_inc;  // slot taken
    logic cnt_dec;  // slot freed or dropped
  } proc_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/art_in_if.sv
// Request channel into the slot table: valid/ready plus command payload.
// No dependencies.
`default_nettype none
interface art_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] packet_id;
  logic [1:0]  qos_level;

  modport source (output valid, cmd, packet_id, qos_level, input ready);
  modport sink   (input valid, cmd, packet_id, qos_level, output ready);
endinterface
`default_nettype wire

// File: rtl/core/art_out_if.sv
// Result channel out of the slot table: valid/ready plus result payload.
// No dependencies.
`default_nettype none
interface art_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [4:0]  slot;
  logic [15:0] resend_id;
  logic [1:0]  resend_qos;
  logic        last;

  modport source (output valid, status, slot, resend_id, resend_qos, last, input ready);
  modport sink   (input valid, status, slot, resend_id, resend_qos, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ack_retransmit_table.sv
// Ack/retransmit slot table. Insert, ack and tick requests hold off the input
// for the accept and one full turn of the cell ring; the turn stalls while a
// result is due and the output is still held. A bad-id ack or an empty tick is answered at once, with no turn.
// The result for slot s is loaded into the output register when slot s is at the head; full and
// not-found results come at the end of the turn.
// Reset (sync, active low) clears slot valid bits and the count, loads 2 and 3.
`default_nettype none
module ack_retransmit_table #(
  parameter int SLOTS = art_pkg::DEF_SLOTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  art_in_if.sink                              in_ch,
  art_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [art_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [art_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import art_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // step counter
  localparam int CW = $clog2(SLOTS + 1);                  // occupancy count

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state_r;
  logic [SW-1:0]     step_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [EMIT_W-1:0] emitted_r;
  logic [EMIT_W-1:0] kmax_r;
  logic [1:0]        cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [QOS_W-1:0]  qos_r;
  logic [CNT2_W-1:0] atr_r;
  logic [CNT2_W-1:0] lim_r;
  logic              out_valid_r;
  res_t              out_r;

  entry_t    cell_q [SLOTS];
  entry_t    cell_d [SLOTS];
  entry_t    head_nxt;
  res_t      p_res;
  proc_ctl_t p_ctl;

  logic   out_free;
  logic   out_load;
  logic   in_acc;
  logic   last_step;
  logic   proceed;
  logic   shift_en;
  cmd_t   in_cmd;
  logic [EMIT_W-1:0] kmax_nxt;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_cmd    = cmd_t'(in_ch.cmd);
  assign last_step = (step_r == SW'(SLOTS - 1));
  // the ring stalls only when a result is due and the output is still held
  assign proceed   = !p_ctl.emit || out_free;
  assign shift_en  = (state_r == S_SCAN) && proceed;

  // a new result enters the output register: immediate answers while idle,
  // or a slot result from the head during the scan
  assign out_load = (state_r == S_IDLE)
                    ? (in_acc && ((in_cmd == CMD_ACK && in_ch.packet_id == '0) ||
                                  (in_cmd == CMD_TICK && cnt_r == '0)))
                    : (shift_en && p_ctl.emit);

  // a tick reports at most MAX_RES slots; the last flag goes on the last one reported
  assign kmax_nxt = (32'(cnt_r) > 32'(MAX_RES)) ? EMIT_W'(MAX_RES) : EMIT_W'(cnt_r);

  // ring of cells: each shifts toward the head, the head comes back
  // processed at the tail, so after SLOTS shifts every slot is in place
  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_tail
        assign cell_d[g] = head_nxt;
      end else begin : g_mid
        assign cell_d[g] = cell_q[g+1];
      end
      art_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (cell_d[g]),
        .q        (cell_q[g])
      );
    end
  endgenerate

  art_proc u_proc (
    .cmd             (cmd_r),
    .pkt_id          (id_r),
    .qos             (qos_r),
    .acks_to_release (atr_r),
    .resend_limit    (lim_r),
    .done            (done_r),
    .last_step       (last_step),
    .slot            (SLOT_FLD_W'(step_r)),
    .emitted         (emitted_r),
    .kmax            (kmax_r),
    .head            (cell_q[0]),
    .head_nxt        (head_nxt),
    .res             (p_res),
    .ctl             (p_ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      done_r      <= 1'b0;
      cnt_r       <= '0;
      emitted_r   <= '0;
      kmax_r      <= '0;
      atr_r       <= ATR_RESET;
      lim_r       <= LIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_ACKS_TO_RELEASE: atr_r <= cfg_wdata;
          REG_RESEND_LIMIT:    lim_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_ch.cmd;
            id_r      <= in_ch.packet_id;
            qos_r     <= in_ch.qos_level;
            step_r    <= '0;
            done_r    <= 1'b0;
            emitted_r <= '0;
            kmax_r    <= kmax_nxt;
            case (in_cmd)
              CMD_INSERT: begin
                state_r <= S_SCAN;
              end
              CMD_ACK: begin
                if (in_ch.packet_id == '0) begin
                  // bad id: answered at once, table untouched
                  out_r <= '{status: ST_BADID, slot: '0, rid: '0,
                             rqos: in_ch.qos_level, last: 1'b1};
                end else begin
                  state_r <= S_SCAN;
                end
              end
              CMD_TICK: begin
                if (cnt_r == '0) begin
                  out_r <= '{status: ST_IDLE, slot: '0, rid: '0,
                             rqos: '0, last: 1'b1};
                end else begin
                  state_r <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (proceed) begin
            step_r <= step_r + SW'(1);
            done_r <= done_r | p_ctl.hit;
            cnt_r  <= cnt_r + CW'(p_ctl.cnt_inc) - CW'(p_ctl.cnt_dec);
            if (p_ctl.emit) begin
              out_r     <= p_res;
              emitted_r <= emitted_r + EMIT_W'(1);
            end
            if (last_step) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.slot       = out_r.slot;
  assign out_ch.resend_id  = out_r.rid;
  assign out_ch.resend_qos = out_r.rqos;
  assign out_ch.last       = out_r.last;

endmodule
`default_nettype wire

// File: rtl/core/art_cell.sv
// One slot of the rotating table: holds an entry and takes its neighbor's
// entry on every shift. Depends on art_pkg.
`default_nettype none
module art_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            shift_en,
  input  wire art_pkg::entry_t d,
  output art_pkg::entry_t      q
);
  import art_pkg::*;

  entry_t ent_r;

  // valid bit only is reset; the rest is undefined until an insert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift_en) begin
      ent_r.valid <= d.valid;
    end
    if (shift_en) begin
      ent_r.id      <= d.id;
      ent_r.qos     <= d.qos;
      ent_r.acks    <= d.acks;
      ent_r.resends <= d.resends;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

// File: rtl/core/art_proc.sv
// Head-of-ring processor: applies insert, ack or tick to the entry at the
// head cell and forms the result for that slot. Depends on art_pkg.
`default_nettype none
module art_proc (
  input  wire logic [1:0]                     cmd,
  input  wire logic [art_pkg::ID_W-1:0]       pkt_id,
  input  wire logic [art_pkg::QOS_W-1:0]      qos,
  input  wire logic [art_pkg::CNT2_W-1:0]     acks_to_release,
  input  wire logic [art_pkg::CNT2_W-1:0]     resend_limit,
  input  wire logic                           done,
  input  wire logic                           last_step,
  input  wire logic [art_pkg::SLOT_FLD_W-1:0] slot,
  input  wire logic [art_pkg::EMIT_W-1:0]     emitted,
  input  wire logic [art_pkg::EMIT_W-1:0]     kmax,
  input  wire art_pkg::entry_t                head,
  output art_pkg::entry_t                     head_nxt,
  output art_pkg::res_t                       res,
  output art_pkg::proc_ctl_t                  ctl
);
  import art_pkg::*;

  logic [CNT2_W-1:0] acks_inc;
  logic [CNT2_W-1:0] rs_inc;
  logic              id_hit;

  assign acks_inc = (head.acks == CNT_MAX) ? CNT_MAX : head.acks + CNT2_W'(1);
  assign rs_inc   = (head.resends == CNT_MAX) ? CNT_MAX : head.resends + CNT2_W'(1);
  assign id_hit   = !done && head.valid && (head.id == pkt_id);

  always_comb begin
    head_nxt   = head;
    ctl        = '0;
    res.status = ST_IDLE;
    res.slot   = slot;
    res.rid    = head.id;
    res.rqos   = head.qos;
    res.last   = 1'b1;
    case (cmd_t'(cmd))
      CMD_INSERT: begin
        if (!done && !head.valid) begin
          head_nxt.valid   = 1'b1;
          head_nxt.id      = pkt_id;
          head_nxt.qos     = qos;
          head_nxt.acks    = '0;
          head_nxt.resends = '0;
          ctl.hit          = 1'b1;
          ctl.emit         = 1'b1;
          ctl.cnt_inc      = 1'b1;
          res.status       = ST_INSERTED;
          res.rid          = pkt_id;
          res.rqos         = qos;
        end else if (!done && last_step) begin
          ctl.emit   = 1'b1;
          res.status = ST_FULL;
          res.slot   = '0;
          res.rid    = pkt_id;
          res.rqos   = qos;
        end
      end
      CMD_ACK: begin
        if (id_hit && head.qos == qos) begin
          head_nxt.valid = 1'b0;
          ctl.hit        = 1'b1;
          ctl.emit       = 1'b1;
          ctl.cnt_dec    = 1'b1;
          res.status     = ST_FREED;
        end else if (id_hit && qos != CNT_MAX && head.qos == qos + QOS_W'(1)) begin
          // ack one QoS level below: count it, free at the threshold
          head_nxt.acks = acks_inc;
          ctl.hit       = 1'b1;
          ctl.emit      = 1'b1;
          if (acks_inc >= acks_to_release) begin
            head_nxt.valid = 1'b0;
            ctl.cnt_dec    = 1'b1;
            res.status     = ST_FREED;
          end else begin
            res.status = ST_COUNTED;
          end
        end else if (!done && last_step) begin
          ctl.emit   = 1'b1;
          res.status = ST_NOTFOUND;
          res.slot   = '0;
          res.rid    = pkt_id;
          res.rqos   = qos;
        end
      end
      CMD_TICK: begin
        if (head.valid) begin
          head_nxt.resends = rs_inc;
          if (rs_inc >= resend_limit) begin
            head_nxt.valid = 1'b0;
            ctl.cnt_dec    = 1'b1;
            res.status     = ST_DROPPED;
          end else begin
            res.status = ST_RESEND;
          end
          // results past the cap are processed but not reported
          ctl.emit = (emitted < EMIT_W'(MAX_RES));
          res.last = (emitted + EMIT_W'(1) == kmax);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
